[sv/vrpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrpm_pkg
// Shared types and constants for the valve reference to PWM duty mapper.
// ----------------------------------------------------------------------------
package vrpm_pkg;

    // Field widths of the ports.
    localparam int REF_W      = 10;
    localparam int GAIN_W     = 8;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int TGT_W      = 11;
    localparam int SPD_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Sizes and scale factors.
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int DUTY_MAX        = 1000;
    localparam int GAIN_FULL_SCALE = 255;
    localparam int REF_MAX         = 1000;
    localparam int PER_MILLE       = 1000;
    localparam int SPEED_MAX       = 1000;

    // Register reset values.
    localparam logic [GAIN_W-1:0] GAIN_MIN_RST   = 8'd0;
    localparam logic [GAIN_W-1:0] GAIN_MAX_RST   = 8'd255;
    localparam logic [REF_W-1:0]  LIMIT_LOW_RST  = 10'd0;
    localparam logic [REF_W-1:0]  LIMIT_HIGH_RST = 10'd1000;
    localparam logic [CNT_W-1:0]  COUNT_RST      = 5'd0;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_GAIN_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_GAIN_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT  = 3'd6;

    // Request kinds.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Working value width of the datapath and of the multiply-divide unit.
    localparam int V_W      = 23;
    localparam int MA_W     = 12;
    localparam int MB_W     = V_W;
    localparam int MD_W     = 17;
    localparam int DIV_BITS = 4;
    localparam int DIV_STEPS = (MA_W + MB_W + DIV_BITS - 1) / DIV_BITS;
    localparam int PROD_W   = DIV_STEPS * DIV_BITS;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    typedef logic signed [V_W-1:0] val_t;

    // One breakpoint as stored in the table memory.
    typedef struct packed {
        logic [REF_W-1:0] ref_val;
        logic [REF_W-1:0] duty_val;
    } entry_t;

    // Multiply-divide request: q = trunc(a * b / d), zero when d is zero.
    typedef struct packed {
        logic                   start;
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
        logic signed [MD_W-1:0] d;
    } md_req_t;

    typedef struct packed {
        logic done;
        val_t q;
    } md_rsp_t;

    // Operations run on the shared unit, in order.
    typedef enum logic [2:0] {
        OP_SPEED = 3'd0,
        OP_MAG   = 3'd1,
        OP_FRAC  = 3'd2,
        OP_REF   = 3'd3,
        OP_REL   = 3'd4,
        OP_DUTY  = 3'd5
    } op_t;

endpackage

[sv/vrpm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrpm_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module vrpm_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[sv/vrpm_muldiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrpm_muldiv
// Shared signed multiply-divide unit: a multiply state, then a restoring
// divider that retires DIV_BITS quotient bits per cycle. Truncates toward zero.
// ----------------------------------------------------------------------------
module vrpm_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  vrpm_pkg::md_req_t req,
    output vrpm_pkg::md_rsp_t rsp
);
    import vrpm_pkg::*;

    typedef enum logic [3:0] {
        MD_IDLE = 4'b0001,
        MD_MUL  = 4'b0010,
        MD_DIV  = 4'b0100,
        MD_DONE = 4'b1000
    } md_state_t;

    md_state_t          state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [MA_W-1:0]    ma_reg;
    logic [MB_W-1:0]    mb_reg;
    logic [MD_W-1:0]    dm_reg;
    logic               neg_reg;
    logic               dzero_reg;
    logic [MA_W+MB_W-1:0] prod;
    logic [PROD_W-1:0]  dv_reg, dv_next;
    logic [MD_W-1:0]    rem_reg, rem_next;
    logic [MD_W:0]      trial;
    logic [V_W-1:0]     q_mag;

    // Magnitude product; signs are handled apart.
    assign prod = ma_reg * mb_reg;

    // DIV_BITS restoring steps. The quotient shifts in at the bottom of the
    // dividend register as the dividend bits leave at the top.
    always_comb
    begin
        rem_next = rem_reg;
        dv_next  = dv_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {rem_next, dv_next[PROD_W-1]};
            if (trial >= {1'b0, dm_reg})
            begin
                rem_next = MD_W'(trial - {1'b0, dm_reg});
                dv_next  = {dv_next[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[MD_W-1:0];
                dv_next  = {dv_next[PROD_W-2:0], 1'b0};
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                step_next  = '0;
                state_next = dzero_reg ? MD_DONE : MD_DIV;
            end
            MD_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = MD_DONE;
                end
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Operand capture and datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == MD_IDLE && req.start)
        begin
            ma_reg    <= MA_W'(req.a[MA_W-1] ? -req.a : req.a);
            mb_reg    <= MB_W'(req.b[MB_W-1] ? -req.b : req.b);
            dm_reg    <= MD_W'(req.d[MD_W-1] ? -req.d : req.d);
            neg_reg   <= req.a[MA_W-1] ^ req.b[MB_W-1] ^ req.d[MD_W-1];
            dzero_reg <= (req.d == '0);
        end
        if (state_reg == MD_MUL)
        begin
            dv_reg  <= dzero_reg ? '0 : PROD_W'(prod);
            rem_reg <= '0;
        end
        if (state_reg == MD_DIV)
        begin
            dv_reg  <= dv_next;
            rem_reg <= rem_next;
        end
    end

    assign q_mag    = dv_reg[V_W-1:0];
    assign rsp.done = (state_reg == MD_DONE);
    assign rsp.q    = neg_reg ? val_t'(-q_mag) : val_t'(q_mag);

    // A new request only lands on an idle unit.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == MD_IDLE)
        else $error("multiply-divide request while busy");

    // The divider never runs past its last step.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == MD_DIV |-> step_reg < STEP_W'(DIV_STEPS))
        else $error("divider step out of range");

    // A zero divisor gives a zero quotient.
    a_dzero_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == MD_DONE && dzero_reg |-> rsp.q == '0)
        else $error("nonzero quotient for zero divisor");

endmodule

[sv/valve_reference_pwm_mapper_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_reference_pwm_mapper_core
// Maps a signed valve target to a reference and then, through a breakpoint
// table with linear interpolation, to a PWM duty.
// ----------------------------------------------------------------------------
// A load request writes its breakpoint and leaves the block idle. A step runs
// the speed, magnitude, fraction and reference operations when enabled with a
// nonzero target, then walks the breakpoints in use and interpolates; with fewer
// than two breakpoints it skips the walk and gives a zero duty. The next request
// is taken in the cycle after the result is registered. The divider retires 4
// quotient bits a cycle and is skipped for a zero divisor. Reset restores the
// register defaults; the table is not cleared.
module valve_reference_pwm_mapper_core #(
    parameter int TABLE_DEPTH = vrpm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port
    input  logic                               cfg_we,
    input  logic [vrpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vrpm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Request channel
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               action,
    input  logic [vrpm_pkg::IDX_W-1:0]         entry_index,
    input  logic [vrpm_pkg::REF_W-1:0]         entry_ref,
    input  logic [vrpm_pkg::REF_W-1:0]         entry_duty,
    input  logic                               enabled,
    input  logic signed [vrpm_pkg::TGT_W-1:0]  target,
    input  logic [vrpm_pkg::SPD_W-1:0]         speed_scale,
    // Result channel
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [vrpm_pkg::REF_W-1:0]         duty,
    output logic [vrpm_pkg::REF_W-1:0]         reference
);
    import vrpm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    function automatic logic [REF_W-1:0] clamp_ref(input val_t v);
        logic [REF_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (int'(v) > REF_MAX)
        begin
            r = REF_W'(REF_MAX);
        end
        else
        begin
            r = REF_W'(v);
        end
        return r;
    endfunction

    function automatic logic [REF_W-1:0] clamp_duty(input val_t v);
        logic [REF_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (int'(v) > DUTY_MAX)
        begin
            r = REF_W'(DUTY_MAX);
        end
        else
        begin
            r = REF_W'(v);
        end
        return r;
    endfunction

    // Control state
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic               out_valid_reg;
    logic [CW-1:0]      cnt_reg;
    logic               scan_dv_reg;
    logic               hi_found_reg;

    // Configuration registers
    logic [GAIN_W-1:0]  pos_gain_min_reg, pos_gain_max_reg;
    logic [GAIN_W-1:0]  neg_gain_min_reg, neg_gain_max_reg;
    logic [REF_W-1:0]   limit_low_reg, limit_high_reg;
    logic [CNT_W-1:0]   table_count_reg;

    // Step operands and working values
    logic [GAIN_W-1:0]  gmin_reg, gmax_reg;
    logic [REF_W-1:0]   lim_reg;
    logic [REF_W-1:0]   mid_reg;
    logic [TGT_W-1:0]   mag_reg;
    logic [SPD_W-1:0]   speed_reg;
    val_t               t_reg;
    logic [REF_W-1:0]   x_reg;
    logic [REF_W-1:0]   res_duty_reg;
    logic [AW-1:0]      didx_reg;
    entry_t             first_reg, lo_reg, hi_reg;
    logic [REF_W-1:0]   duty_reg, reference_reg;

    // Combinational helpers
    logic               step_accept, load_accept;
    logic               tgt_neg, tgt_nonzero, math_needed;
    logic signed [REF_W+1:0] lim_diff, lim_half, mid_full;
    logic [REF_W-1:0]   mid_now;
    logic [CW-1:0]      n_count, n_last;
    logic               short_table, scan_issue, scan_last, scan_mid_idx;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    entry_t             ram_wdata, rd_entry;
    logic [$bits(entry_t)-1:0] ram_rdata;
    md_req_t            md_req;
    md_rsp_t            md_rsp;
    val_t               base, sum;

    assign item_ready  = (state_reg == ST_IDLE);
    assign step_accept = item_valid && item_ready && (action == ACT_STEP);
    assign load_accept = item_valid && item_ready && (action == ACT_LOAD);

    // Midpoint of the limits, halving toward zero.
    assign lim_diff = signed'({2'b00, limit_high_reg}) - signed'({2'b00, limit_low_reg});
    assign lim_half = (lim_diff + ((lim_diff < 0) ? 12'sd1 : 12'sd0)) >>> 1;
    assign mid_full = lim_half + signed'({2'b00, limit_low_reg});
    assign mid_now  = mid_full[REF_W-1:0];

    assign tgt_neg     = target[TGT_W-1];
    assign tgt_nonzero = (target != '0);
    assign math_needed = enabled && tgt_nonzero;

    // Breakpoints in use, saturated at the table depth.
    assign n_count = (int'(table_count_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                          : CW'(table_count_reg);
    assign n_last      = n_count - CW'(1);
    assign short_table = (n_count < CW'(2));
    assign scan_issue  = (state_reg == ST_SCAN) && !short_table && (cnt_reg < n_count);
    assign scan_last   = scan_dv_reg && (CW'(didx_reg) == n_last);
    assign scan_mid_idx = (CW'(didx_reg) < n_last);

    // Breakpoint table.
    assign ram_we    = load_accept && (int'(entry_index) < TABLE_DEPTH);
    assign ram_waddr = AW'(entry_index);
    assign ram_wdata = '{ref_val: entry_ref, duty_val: entry_duty};
    assign ram_raddr = cnt_reg[AW-1:0];
    assign rd_entry  = entry_t'(ram_rdata);

    vrpm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Operand selection for the shared multiply-divide unit.
    always_comb
    begin
        md_req.start = (state_reg == ST_ISSUE);
        md_req.a     = '0;
        md_req.b     = '0;
        md_req.d     = MD_W'(PER_MILLE);
        base         = '0;
        unique case (op_reg)
            OP_SPEED:
            begin
                md_req.a = MA_W'(gmax_reg) - MA_W'(gmin_reg);
                md_req.b = MB_W'(speed_reg);
                base     = V_W'(gmin_reg);
            end
            OP_MAG:
            begin
                md_req.a = MA_W'(t_reg) - MA_W'(gmin_reg);
                md_req.b = MB_W'(mag_reg);
                base     = V_W'(gmin_reg);
            end
            OP_FRAC:
            begin
                md_req.a = MA_W'(t_reg);
                md_req.b = MB_W'(PER_MILLE);
                md_req.d = MD_W'(GAIN_FULL_SCALE);
            end
            OP_REF:
            begin
                md_req.a = MA_W'(lim_reg) - MA_W'(mid_reg);
                md_req.b = t_reg;
                base     = V_W'(mid_reg);
            end
            OP_REL:
            begin
                md_req.a = MA_W'(x_reg) - MA_W'(lo_reg.ref_val);
                md_req.b = MB_W'(PER_MILLE);
                md_req.d = MD_W'(hi_reg.ref_val) - MD_W'(lo_reg.ref_val);
            end
            OP_DUTY:
            begin
                md_req.a = MA_W'(hi_reg.duty_val) - MA_W'(lo_reg.duty_val);
                md_req.b = t_reg;
                base     = V_W'(lo_reg.duty_val);
            end
            default:
            begin
                md_req.a = '0;
            end
        endcase
    end

    assign sum = base + md_rsp.q;

    vrpm_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_accept)
                begin
                    op_next    = OP_SPEED;
                    state_next = math_needed ? ST_ISSUE : ST_SCAN;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    unique case (op_reg)
                        OP_SPEED: begin op_next = OP_MAG;  state_next = ST_ISSUE; end
                        OP_MAG:   begin op_next = OP_FRAC; state_next = ST_ISSUE; end
                        OP_FRAC:  begin op_next = OP_REF;  state_next = ST_ISSUE; end
                        OP_REF:   begin state_next = ST_SCAN; end
                        OP_REL:   begin op_next = OP_DUTY; state_next = ST_ISSUE; end
                        OP_DUTY:  begin state_next = ST_OUT; end
                        default:  begin state_next = ST_IDLE; end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (short_table)
                begin
                    state_next = ST_OUT;
                end
                else if (scan_last)
                begin
                    op_next    = OP_REL;
                    state_next = ST_ISSUE;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_SPEED;
            out_valid_reg    <= 1'b0;
            cnt_reg          <= '0;
            scan_dv_reg      <= 1'b0;
            hi_found_reg     <= 1'b0;
            pos_gain_min_reg <= GAIN_MIN_RST;
            pos_gain_max_reg <= GAIN_MAX_RST;
            neg_gain_min_reg <= GAIN_MIN_RST;
            neg_gain_max_reg <= GAIN_MAX_RST;
            limit_low_reg    <= LIMIT_LOW_RST;
            limit_high_reg   <= LIMIT_HIGH_RST;
            table_count_reg  <= COUNT_RST;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POS_GAIN_MIN: pos_gain_min_reg <= cfg_wdata[GAIN_W-1:0];
                    REG_POS_GAIN_MAX: pos_gain_max_reg <= cfg_wdata[GAIN_W-1:0];
                    REG_NEG_GAIN_MIN: neg_gain_min_reg <= cfg_wdata[GAIN_W-1:0];
                    REG_NEG_GAIN_MAX: neg_gain_max_reg <= cfg_wdata[GAIN_W-1:0];
                    REG_LIMIT_LOW:    limit_low_reg    <= cfg_wdata[REF_W-1:0];
                    REG_LIMIT_HIGH:   limit_high_reg   <= cfg_wdata[REF_W-1:0];
                    REG_TABLE_COUNT:  table_count_reg  <= cfg_wdata[CNT_W-1:0];
                    default:          ;
                endcase
            end

            // Output register: loaded when the result is done and the slot is free.
            if (state_reg == ST_OUT && (!out_valid_reg || result_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Table walk: one read issued per cycle.
            if (step_accept)
            begin
                cnt_reg      <= '0;
                hi_found_reg <= 1'b0;
            end
            else if (scan_issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            scan_dv_reg <= scan_issue;

            if (scan_dv_reg && didx_reg != '0 && rd_entry.ref_val >= x_reg)
            begin
                hi_found_reg <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        // Capture the direction-specific operands of a step.
        if (step_accept)
        begin
            gmin_reg  <= tgt_neg ? neg_gain_min_reg : pos_gain_min_reg;
            gmax_reg  <= tgt_neg ? neg_gain_max_reg : pos_gain_max_reg;
            lim_reg   <= tgt_neg ? limit_low_reg : limit_high_reg;
            mid_reg   <= mid_now;
            mag_reg   <= TGT_W'(tgt_neg ? -target : target);
            speed_reg <= (int'(speed_scale) > SPEED_MAX) ? SPD_W'(SPEED_MAX) : speed_scale;
            x_reg     <= clamp_ref(V_W'(mid_now));
        end

        // Results of the shared unit.
        if (state_reg == ST_WAIT && md_rsp.done)
        begin
            case (op_reg)
                OP_REF:  x_reg        <= clamp_ref(sum);
                OP_DUTY: res_duty_reg <= clamp_duty(sum);
                default: t_reg        <= sum;
            endcase
        end

        if (state_reg == ST_SCAN && short_table)
        begin
            res_duty_reg <= '0;
        end

        // Walk the table: remember the first entry, the last entry below the
        // reference and the first entry at or above it.
        if (scan_issue)
        begin
            didx_reg <= cnt_reg[AW-1:0];
        end
        if (scan_dv_reg)
        begin
            if (didx_reg == '0)
            begin
                first_reg <= rd_entry;
            end
            if (scan_mid_idx && rd_entry.ref_val < x_reg)
            begin
                lo_reg <= rd_entry;
            end
            if (didx_reg != '0 && rd_entry.ref_val >= x_reg && !hi_found_reg && !scan_last)
            begin
                hi_reg <= rd_entry;
            end
            // At the last entry settle the pair, clamping at both ends.
            if (scan_last)
            begin
                if (x_reg <= first_reg.ref_val)
                begin
                    lo_reg <= first_reg;
                    hi_reg <= first_reg;
                end
                else if (x_reg >= rd_entry.ref_val)
                begin
                    lo_reg <= rd_entry;
                    hi_reg <= rd_entry;
                end
                else if (!hi_found_reg)
                begin
                    hi_reg <= rd_entry;
                end
            end
        end

        if (state_reg == ST_OUT && (!out_valid_reg || result_ready))
        begin
            duty_reg      <= res_duty_reg;
            reference_reg <= x_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign duty         = duty_reg;
    assign reference    = reference_reg;

    // A step request makes the block busy in the next cycle.
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step_accept |=> !item_ready)
        else $error("ready after a step request was taken");

    // The reported reference is always within the clamp range.
    a_ref_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> int'(reference) <= REF_MAX)
        else $error("reference above its clamp");

    // Table reads stay within the breakpoints in use.
    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        scan_dv_reg |-> CW'(didx_reg) < n_count)
        else $error("table read beyond the breakpoints in use");

    // The unit only finishes while the sequencer waits for it.
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> state_reg == ST_WAIT)
        else $error("multiply-divide result outside the wait state");

endmodule

[test/valve_reference_pwm_mapper_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_reference_pwm_mapper_core_tb
// Self-checking bench for the valve reference to PWM duty mapper. Load and
// step requests go in through a randomly stalling driver. A predictor of the
// reference scaling and the breakpoint interpolation keeps its own copy of
// the registers and the table, and the monitor compares each duty and
// reference with the oldest prediction. The run covers several register
// settings, register extremes among them.
// ----------------------------------------------------------------------------
module valve_reference_pwm_mapper_core_tb;
    import vrpm_pkg::*;

    // The configuration port has no register at this index.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic                     act;
        logic [IDX_W-1:0]         idx;
        logic [REF_W-1:0]         bp_ref;
        logic [REF_W-1:0]         bp_duty;
        logic                     en;
        logic signed [TGT_W-1:0]  tgt;
        logic [SPD_W-1:0]         spd;
    } valve_request_t;

    typedef struct {
        logic [REF_W-1:0] duty;
        logic [REF_W-1:0] reference;
    } duty_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic action = ACT_LOAD;
    logic [IDX_W-1:0] entry_index = '0;
    logic [REF_W-1:0] entry_ref = '0;
    logic [REF_W-1:0] entry_duty = '0;
    logic enabled = 1'b0;
    logic signed [TGT_W-1:0] target = '0;
    logic [SPD_W-1:0] speed_scale = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [REF_W-1:0] duty;
    logic [REF_W-1:0] reference;

    // Mirror of the registers and of the breakpoint table.
    logic [GAIN_W-1:0] pos_gain_lo = GAIN_MIN_RST;
    logic [GAIN_W-1:0] pos_gain_hi = GAIN_MAX_RST;
    logic [GAIN_W-1:0] neg_gain_lo = GAIN_MIN_RST;
    logic [GAIN_W-1:0] neg_gain_hi = GAIN_MAX_RST;
    logic [REF_W-1:0] ref_floor = LIMIT_LOW_RST;
    logic [REF_W-1:0] ref_ceiling = LIMIT_HIGH_RST;
    logic [CNT_W-1:0] points_in_use = COUNT_RST;
    logic [REF_W-1:0] map_ref [TABLE_DEPTH_DEF];
    logic [REF_W-1:0] map_duty [TABLE_DEPTH_DEF];

    valve_request_t valve_requests [$];
    duty_point_t predicted_points [$];
    duty_point_t oldest_point;
    int error_count = 0;
    bit steady_flow = 1'b0;

    valve_reference_pwm_mapper_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .entry_index  (entry_index),
        .entry_ref    (entry_ref),
        .entry_duty   (entry_duty),
        .enabled      (enabled),
        .target       (target),
        .speed_scale  (speed_scale),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .duty         (duty),
        .reference    (reference)
    );

    always #2 clk = ~clk;

    // Per mille blend from a toward b, truncating toward zero.
    function automatic longint blend(longint t, longint a, longint b);
        return a + ((b - a) * t) / PER_MILLE;
    endfunction

    // Per mille position of x between a and b; zero for an empty span.
    function automatic longint ratio(longint x, longint a, longint b);
        if (b == a)
            return 0;
        return ((x - a) * PER_MILLE) / (b - a);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Interpolates a reference through the breakpoints in use, holding the
    // end duties outside the covered span.
    function automatic longint interpolate_duty(longint x);
        int n;
        int lo;
        int hi;
        n = (points_in_use > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(points_in_use);
        if (n < 2)
            return 0;
        lo = n - 1;
        hi = 0;
        if (x <= longint'(map_ref[0])) begin
            lo = 0;
            hi = 0;
        end
        else if (x >= longint'(map_ref[n-1])) begin
            lo = n - 1;
            hi = n - 1;
        end
        else begin
            for (int k = n - 1; k > 0; k--) begin
                if (longint'(map_ref[k-1]) < x) begin
                    lo = k - 1;
                    break;
                end
            end
            for (int k = 1; k < n; k++) begin
                if (longint'(map_ref[k]) >= x) begin
                    hi = k;
                    break;
                end
            end
        end
        return blend(ratio(x, map_ref[lo], map_ref[hi]), map_duty[lo], map_duty[hi]);
    endfunction

    // Works out the reference and duty that one step request produces.
    function automatic duty_point_t map_target_to_duty(logic en, logic signed [TGT_W-1:0] tgt,
                                                       logic [SPD_W-1:0] spd);
        duty_point_t point;
        longint mid;
        longint refv;
        longint tv;
        longint sv;
        longint g_lo;
        longint g_hi;
        longint mag;
        longint gain;
        longint frac;
        mid = (longint'(ref_ceiling) - longint'(ref_floor)) / 2 + longint'(ref_floor);
        refv = mid;
        if (en) begin
            tv = longint'(tgt);
            sv = clip(longint'(spd), 0, SPEED_MAX);
            if (tv != 0) begin
                g_lo = (tv > 0) ? longint'(pos_gain_lo) : longint'(neg_gain_lo);
                g_hi = (tv > 0) ? longint'(pos_gain_hi) : longint'(neg_gain_hi);
                mag = (tv > 0) ? tv : -tv;
                gain = blend(mag, g_lo, blend(sv, g_lo, g_hi));
                frac = ratio(gain, 0, GAIN_FULL_SCALE);
                refv = blend(frac, mid, (tv > 0) ? longint'(ref_ceiling)
                                                 : longint'(ref_floor));
            end
        end
        refv = clip(refv, 0, REF_MAX);
        point.reference = refv[REF_W-1:0];
        point.duty = REF_W'(clip(interpolate_duty(refv), 0, DUTY_MAX));
        return point;
    endfunction

    // Driver: mirrors each accepted load, predicts each accepted step, then presents the next request.
    always @(posedge clk) begin
        if (!rst_n) begin
            item_valid <= 1'b0;
        end
        else begin
            if (item_valid && item_ready) begin
                if (action == ACT_LOAD) begin
                    if (entry_index < TABLE_DEPTH_DEF) begin
                        map_ref[entry_index] = entry_ref;
                        map_duty[entry_index] = entry_duty;
                    end
                end
                else begin
                    predicted_points.push_back(map_target_to_duty(enabled, target, speed_scale));
                end
            end
            if (!item_valid || item_ready) begin
                if (valve_requests.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 38))
                begin
                    item_valid <= 1'b1;
                    action <= valve_requests[0].act;
                    entry_index <= valve_requests[0].idx;
                    entry_ref <= valve_requests[0].bp_ref;
                    entry_duty <= valve_requests[0].bp_duty;
                    enabled <= valve_requests[0].en;
                    target <= valve_requests[0].tgt;
                    speed_scale <= valve_requests[0].spd;
                    void'(valve_requests.pop_front());
                end
                else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk) begin
        if (!rst_n) begin
            result_ready <= 1'b0;
        end
        else begin
            if (result_valid && result_ready) begin
                if (predicted_points.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual duty %0d ref %0d",
                             $time, duty, reference);
                    error_count++;
                end
                else begin
                    oldest_point = predicted_points.pop_front();
                    if (duty !== oldest_point.duty) begin
                        $display("%0t: duty mismatch, expected %0d, actual %0d",
                                 $time, oldest_point.duty, duty);
                        error_count++;
                    end
                    if (reference !== oldest_point.reference) begin
                        $display("%0t: reference mismatch, expected %0d, actual %0d",
                                 $time, oldest_point.reference, reference);
                        error_count++;
                    end
                end
            end
            result_ready <= steady_flow || ($urandom_range(0, 99) >= 38);
        end
    end

    task automatic push_load(int idx, int bp_ref, int bp_duty);
        valve_request_t req;
        req.act = ACT_LOAD;
        req.idx = idx[IDX_W-1:0];
        req.bp_ref = bp_ref[REF_W-1:0];
        req.bp_duty = bp_duty[REF_W-1:0];
        req.en = 1'($urandom_range(0, 1));
        req.tgt = TGT_W'($urandom);
        req.spd = SPD_W'($urandom);
        valve_requests.push_back(req);
    endtask

    task automatic push_step(bit en, int tgt, int spd);
        valve_request_t req;
        req.act = ACT_STEP;
        req.idx = IDX_W'($urandom);
        req.bp_ref = REF_W'($urandom);
        req.bp_duty = REF_W'($urandom);
        req.en = en;
        req.tgt = tgt[TGT_W-1:0];
        req.spd = spd[SPD_W-1:0];
        valve_requests.push_back(req);
    endtask

    // One register write; the mirror follows the same field widths.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        logic [CFG_DATA_W-1:0] wdata;
        wdata = data[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= wdata;
        case (idx)
            REG_POS_GAIN_MIN: pos_gain_lo = wdata[GAIN_W-1:0];
            REG_POS_GAIN_MAX: pos_gain_hi = wdata[GAIN_W-1:0];
            REG_NEG_GAIN_MIN: neg_gain_lo = wdata[GAIN_W-1:0];
            REG_NEG_GAIN_MAX: neg_gain_hi = wdata[GAIN_W-1:0];
            REG_LIMIT_LOW:    ref_floor = wdata[REF_W-1:0];
            REG_LIMIT_HIGH:   ref_ceiling = wdata[REF_W-1:0];
            REG_TABLE_COUNT:  points_in_use = wdata[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(int pmin, int pmax, int nmin, int nmax,
                                  int lo, int hi, int cnt);
        write_reg(REG_POS_GAIN_MIN, pmin);
        write_reg(REG_POS_GAIN_MAX, pmax);
        write_reg(REG_NEG_GAIN_MIN, nmin);
        write_reg(REG_NEG_GAIN_MAX, nmax);
        write_reg(REG_LIMIT_LOW, lo);
        write_reg(REG_LIMIT_HIGH, hi);
        write_reg(REG_TABLE_COUNT, cnt);
        // A write to an unused index must leave every register alone.
        write_reg(REG_UNUSED, $urandom_range(0, 1023));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every request is taken and every result is back, then
    // lets the last load settle before the registers change.
    task automatic drain();
        while (valve_requests.size() != 0 || item_valid || predicted_points.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial begin
        int bp_pos;
        int roll;
        int tgt;
        int spd;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings, empty table in use: fill every breakpoint slot so
        // no later lookup can touch an unwritten entry. All duties stay within the
        // duty limit.
        for (int k = 0; k < TABLE_DEPTH_DEF; k++)
            push_load(k, (k == 7) ? 410 : 50 + k * 60, (k * 137) % 1024);
        push_step(1'b0, 0, 0);
        push_step(1'b1, 1000, 1000);
        push_step(1'b1, -1000, 1000);
        drain();

        // Full table with default gains: the ends of the target and speed
        // ranges, a zero target and the disabled midpoint.
        apply_settings(0, 255, 0, 255, 0, 1000, 16);
        push_step(1'b0, 1000, 1000);
        push_step(1'b1, 0, 1000);
        push_step(1'b1, 1000, 1000);
        push_step(1'b1, -1000, 1000);
        push_step(1'b1, 1023, 1023);
        push_step(1'b1, -1024, 1023);
        push_step(1'b1, 1, 0);
        push_step(1'b1, 500, 500);
        drain();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_settings(255, 255, 255, 255, 0, 1000, 16);
                1: apply_settings(0, 0, 0, 0, 500, 500, 2);
                2: apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                                  1023, 0, 31);
                3: apply_settings($urandom_range(0, 255), 255, $urandom_range(0, 255), 255,
                                  $urandom_range(0, 400), $urandom_range(600, 1023), 1);
                4: apply_settings(0, 255, 0, 255, 0, 1000, 17);
                default: apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                                        $urandom_range(0, 31));
            endcase
            steady_flow = (ph == 4);

            // Every other phase reloads an ascending table; a zero step gives
            // equal neighbouring references.
            if (ph % 2 == 0) begin
                bp_pos = $urandom_range(0, 100);
                for (int k = 0; k < TABLE_DEPTH_DEF; k++) begin
                    push_load(k, bp_pos, $urandom_range(0, 1023));
                    bp_pos = bp_pos + $urandom_range(0, 70);
                    if (bp_pos > 1023)
                        bp_pos = 1023;
                end
            end

            for (int n = 0; n < 58; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    push_load($urandom_range(0, 15), $urandom_range(0, 1023),
                              $urandom_range(0, 1023));
                end
                else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 10)
                        tgt = 0;
                    else if (roll < 25)
                        case ($urandom_range(0, 3))
                            0: tgt = 1000;
                            1: tgt = -1000;
                            2: tgt = 1023;
                            default: tgt = -1024;
                        endcase
                    else if (roll < 40)
                        tgt = $urandom_range(0, 40) - 20;
                    else
                        tgt = $signed(11'($urandom));
                    roll = $urandom_range(0, 99);
                    if (roll < 10)
                        spd = $urandom_range(1001, 1023);
                    else if (roll < 20)
                        spd = (roll < 15) ? 0 : 1000;
                    else
                        spd = $urandom_range(0, 1000);
                    push_step($urandom_range(0, 99) < 85, tgt, spd);
                end
            end
            drain();
            steady_flow = 1'b0;
        end

        repeat (100) @(posedge clk);
        if (predicted_points.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, predicted_points.size());
            error_count++;
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard stop if the block hangs.
    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
